// ===== sv/mc2d_pkg.sv =====
// shared types and constants for the multichannel convolution engine
`timescale 1ns / 1ps
`default_nettype none
package mc2d_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_X = 2'd0,
        OP_LOAD_W = 2'd1,
        OP_CONV   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        K_LOAD_X,
        K_LOAD_W,
        K_CONV,
        K_ERR
    } t_kind;

    typedef enum logic [2:0] {
        CFG_IN_ROWS  = 3'd0,
        CFG_IN_COLS  = 3'd1,
        CFG_IN_CH    = 3'd2,
        CFG_OUT_CH   = 3'd3,
        CFG_K_ROWS   = 3'd4,
        CFG_K_COLS   = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    localparam logic [4:0] RST_IN_ROWS = 5'd12;
    localparam logic [4:0] RST_IN_COLS = 5'd12;
    localparam logic [3:0] RST_IN_CH   = 4'd6;
    localparam logic [4:0] RST_OUT_CH  = 5'd16;
    localparam logic [2:0] RST_K_ROWS  = 3'd5;
    localparam logic [2:0] RST_K_COLS  = 3'd5;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    localparam int RES_W = 40;

    // sizes in use, already clamped to the store bounds
    typedef struct packed {
        logic [4:0] n_rows;
        logic [4:0] n_cols;
        logic [3:0] n_ich;
        logic [4:0] n_och;
        logic [2:0] k_rows;
        logic [2:0] k_cols;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  oc;
        logic [2:0]  ic;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [15:0] value;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

// ===== sv/mc2d_front.sv =====
// front end: configuration registers, bounds checks and command classification
`timescale 1ns / 1ps
`default_nettype none
module mc2d_front
    import mc2d_pkg::*;
#(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int MAX_IN_CH  = 8,
    parameter int MAX_OUT_CH = 16,
    parameter int MAX_KERNEL = 7
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_cfg_ready,
    input  wire logic                  i_start,
    input  wire logic [1:0]            i_operation,
    input  wire logic [3:0]            i_out_channel,
    input  wire logic [2:0]            i_in_channel,
    input  wire logic [3:0]            i_row,
    input  wire logic [3:0]            i_col,
    input  wire logic signed [15:0]    i_value,
    input  wire t_q_stat               i_q_stat,
    output logic                       o_busy,
    output logic                       o_push,
    output t_cmd                       o_cmd,
    output t_cfg                       o_cfg
);

    logic [4:0] r_in_rows;
    logic [4:0] r_in_cols;
    logic [3:0] r_in_ch;
    logic [4:0] r_out_ch;
    logic [2:0] r_k_rows;
    logic [2:0] r_k_cols;

    t_cfg       cfg;
    logic       keep;
    t_kind      kind;
    logic [5:0] row_end;
    logic [5:0] col_end;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_rows <= RST_IN_ROWS;
            r_in_cols <= RST_IN_COLS;
            r_in_ch   <= RST_IN_CH;
            r_out_ch  <= RST_OUT_CH;
            r_k_rows  <= RST_K_ROWS;
            r_k_cols  <= RST_K_COLS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IN_ROWS: r_in_rows <= i_cfg_data;
                CFG_IN_COLS: r_in_cols <= i_cfg_data;
                CFG_IN_CH:   r_in_ch   <= i_cfg_data[3:0];
                CFG_OUT_CH:  r_out_ch  <= i_cfg_data;
                CFG_K_ROWS:  r_k_rows  <= i_cfg_data[2:0];
                CFG_K_COLS:  r_k_cols  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // a size above its store bound acts as the bound
    always_comb begin
        cfg.n_rows = (32'(r_in_rows) > MAX_ROWS)   ? 5'(MAX_ROWS)   : r_in_rows;
        cfg.n_cols = (32'(r_in_cols) > MAX_COLS)   ? 5'(MAX_COLS)   : r_in_cols;
        cfg.n_ich  = (32'(r_in_ch)   > MAX_IN_CH)  ? 4'(MAX_IN_CH)  : r_in_ch;
        cfg.n_och  = (32'(r_out_ch)  > MAX_OUT_CH) ? 5'(MAX_OUT_CH) : r_out_ch;
        cfg.k_rows = (32'(r_k_rows)  > MAX_KERNEL) ? 3'(MAX_KERNEL) : r_k_rows;
        cfg.k_cols = (32'(r_k_cols)  > MAX_KERNEL) ? 3'(MAX_KERNEL) : r_k_cols;
    end

    assign o_cfg = cfg;

    // window fits when row + kernel_rows stays within the map
    assign row_end = 6'(i_row) + 6'(cfg.k_rows);
    assign col_end = 6'(i_col) + 6'(cfg.k_cols);

    always_comb begin
        keep = 1'b0;
        kind = K_ERR;
        unique case (i_operation)
            OP_LOAD_X: begin
                kind = K_LOAD_X;
                keep = ({1'b0, i_in_channel} < cfg.n_ich) &&
                       ({1'b0, i_row} < cfg.n_rows) &&
                       ({1'b0, i_col} < cfg.n_cols);
            end
            OP_LOAD_W: begin
                kind = K_LOAD_W;
                keep = ({1'b0, i_out_channel} < cfg.n_och) &&
                       ({1'b0, i_in_channel} < cfg.n_ich) &&
                       (i_row < {1'b0, cfg.k_rows}) &&
                       (i_col < {1'b0, cfg.k_cols});
            end
            OP_CONV: begin
                keep = 1'b1;
                if (({1'b0, i_out_channel} < cfg.n_och) &&
                    (cfg.k_rows != 3'd0) && (cfg.k_cols != 3'd0) &&
                    (row_end <= 6'(cfg.n_rows)) && (col_end <= 6'(cfg.n_cols))) begin
                    kind = K_CONV;
                end else begin
                    kind = K_ERR;
                end
            end
            default: begin
                keep = 1'b0;
                kind = K_ERR;
            end
        endcase
    end

    assign o_busy = i_q_stat.full;
    assign o_push = i_start && !i_q_stat.full && keep;

    always_comb begin
        o_cmd.kind  = kind;
        o_cmd.oc    = i_out_channel;
        o_cmd.ic    = i_in_channel;
        o_cmd.row   = i_row;
        o_cmd.col   = i_col;
        o_cmd.value = i_value;
    end

endmodule
`default_nettype wire

// ===== sv/mc2d_fifo.sv =====
// short command queue between front end and back end
`timescale 1ns / 1ps
`default_nettype none
module mc2d_fifo
    import mc2d_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output t_q_stat   o_stat
);

    localparam int CNT_W = Q_PTR_W + 1;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [CNT_W-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule
`default_nettype wire

// ===== sv/mc2d_back.sv =====
// back end: sample and weight stores, tap sequencer and multiply-accumulate
`timescale 1ns / 1ps
`default_nettype none
module mc2d_back
    import mc2d_pkg::*;
#(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int MAX_IN_CH  = 8,
    parameter int MAX_OUT_CH = 16,
    parameter int MAX_KERNEL = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire t_q_stat          i_q_stat,
    input  wire t_cmd             i_head,
    output logic                  o_pop,
    output logic                  o_strobe,
    output logic signed [RES_W-1:0] o_result,
    output logic                  o_error
);

    localparam int IN_DEPTH   = MAX_IN_CH * MAX_ROWS * MAX_COLS;
    localparam int W_DEPTH    = MAX_OUT_CH * MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
    localparam int IA_W       = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
    localparam int WA_W       = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int W_CH_STEP  = MAX_KERNEL * MAX_KERNEL;
    localparam int W_OC_STEP  = MAX_IN_CH * W_CH_STEP;
    localparam int X_CH_STEP  = MAX_ROWS * MAX_COLS;

    logic [15:0] r_x_mem [IN_DEPTH];
    logic [15:0] r_w_mem [W_DEPTH];

    t_state r_state, n_state;
    logic [3:0] r_t, n_t;
    logic [2:0] r_i, n_i;
    logic [2:0] r_j, n_j;
    logic [WA_W-1:0] r_w_addr, n_w_addr;
    logic [WA_W-1:0] r_w_row, n_w_row;
    logic [WA_W-1:0] r_w_chan, n_w_chan;
    logic [IA_W-1:0] r_x_addr, n_x_addr;
    logic [IA_W-1:0] r_x_row, n_x_row;
    logic [IA_W-1:0] r_x_chan, n_x_chan;
    logic signed [RES_W-1:0] r_acc, n_acc;
    logic r_strobe, n_strobe;
    logic signed [RES_W-1:0] r_result, n_result;
    logic r_error, n_error;

    logic r_v1, r_v2;
    logic signed [15:0] r_x_rd;
    logic signed [15:0] r_w_rd;
    logic signed [31:0] r_prod;

    logic x_we, w_we;
    logic [IA_W-1:0] x_waddr;
    logic [WA_W-1:0] w_waddr;
    logic [WA_W-1:0] conv_w_base;
    logic [IA_W-1:0] conv_x_base;

    assign x_waddr = IA_W'((32'(i_head.ic) * MAX_ROWS + 32'(i_head.row)) * MAX_COLS
                           + 32'(i_head.col));
    assign w_waddr = WA_W'(((32'(i_head.oc) * MAX_IN_CH + 32'(i_head.ic)) * MAX_KERNEL
                            + 32'(i_head.row)) * MAX_KERNEL + 32'(i_head.col));
    assign conv_w_base = WA_W'(32'(i_head.oc) * W_OC_STEP);
    assign conv_x_base = IA_W'(32'(i_head.row) * MAX_COLS + 32'(i_head.col));

    always_ff @(posedge i_clk) begin
        if (x_we) begin
            r_x_mem[x_waddr] <= i_head.value;
        end
        r_x_rd <= r_x_mem[r_x_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_w_mem[w_waddr] <= i_head.value;
        end
        r_w_rd <= r_w_mem[r_w_addr];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_w_rd * r_x_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_v1     <= (r_state == ST_RUN);
            r_v2     <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t      <= n_t;
        r_i      <= n_i;
        r_j      <= n_j;
        r_w_addr <= n_w_addr;
        r_w_row  <= n_w_row;
        r_w_chan <= n_w_chan;
        r_x_addr <= n_x_addr;
        r_x_row  <= n_x_row;
        r_x_chan <= n_x_chan;
        r_acc    <= n_acc;
        r_result <= n_result;
        r_error  <= n_error;
    end

    always_comb begin
        n_state  = r_state;
        n_t      = r_t;
        n_i      = r_i;
        n_j      = r_j;
        n_w_addr = r_w_addr;
        n_w_row  = r_w_row;
        n_w_chan = r_w_chan;
        n_x_addr = r_x_addr;
        n_x_row  = r_x_row;
        n_x_chan = r_x_chan;
        n_strobe = 1'b0;
        n_result = r_result;
        n_error  = r_error;
        n_acc    = r_v2 ? r_acc + {{(RES_W-32){r_prod[31]}}, r_prod} : r_acc;
        o_pop    = 1'b0;
        x_we     = 1'b0;
        w_we     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    unique case (i_head.kind)
                        K_LOAD_X: x_we = 1'b1;
                        K_LOAD_W: w_we = 1'b1;
                        K_ERR: begin
                            n_strobe = 1'b1;
                            n_result = '0;
                            n_error  = 1'b1;
                        end
                        K_CONV: begin
                            n_t      = '0;
                            n_i      = '0;
                            n_j      = '0;
                            n_w_addr = conv_w_base;
                            n_w_row  = conv_w_base;
                            n_w_chan = conv_w_base;
                            n_x_addr = conv_x_base;
                            n_x_row  = conv_x_base;
                            n_x_chan = conv_x_base;
                            n_acc    = '0;
                            n_error  = 1'b0;
                            // no input channels in use: empty sum
                            if (i_cfg.n_ich == 4'd0) begin
                                n_strobe = 1'b1;
                                n_result = '0;
                            end else begin
                                n_state = ST_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                // one tap read per cycle, walking columns, then rows, then channels
                if (r_j != i_cfg.k_cols - 3'd1) begin
                    n_j      = r_j + 3'd1;
                    n_w_addr = r_w_addr + 1'b1;
                    n_x_addr = r_x_addr + 1'b1;
                end else if (r_i != i_cfg.k_rows - 3'd1) begin
                    n_j      = '0;
                    n_i      = r_i + 3'd1;
                    n_w_row  = r_w_row + WA_W'(MAX_KERNEL);
                    n_w_addr = r_w_row + WA_W'(MAX_KERNEL);
                    n_x_row  = r_x_row + IA_W'(MAX_COLS);
                    n_x_addr = r_x_row + IA_W'(MAX_COLS);
                end else if (r_t != i_cfg.n_ich - 4'd1) begin
                    n_j      = '0;
                    n_i      = '0;
                    n_t      = r_t + 4'd1;
                    n_w_chan = r_w_chan + WA_W'(W_CH_STEP);
                    n_w_row  = r_w_chan + WA_W'(W_CH_STEP);
                    n_w_addr = r_w_chan + WA_W'(W_CH_STEP);
                    n_x_chan = r_x_chan + IA_W'(X_CH_STEP);
                    n_x_row  = r_x_chan + IA_W'(X_CH_STEP);
                    n_x_addr = r_x_chan + IA_W'(X_CH_STEP);
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the read and multiply stages to empty
                if (!r_v1 && !r_v2) begin
                    n_strobe = 1'b1;
                    n_result = r_acc;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;
    assign o_error  = r_error;

endmodule
`default_nettype wire

// ===== sv/multichannel_conv2d_engine.sv =====
// top level of the multichannel valid-mode 2d convolution engine
//
// Command channel: a word is taken at a clock edge with start high and busy low.
// Sample and weight loads write one store entry; out-of-range loads and the
// unused operation code are dropped. A compute word returns one result word.
// Words pass a four-entry queue; busy is high while that queue is full.
// Result channel: o_strobe marks a word on o_result/o_error for one cycle;
// the receiver always takes it, so nothing stalls the output.
// Configuration channel: i_cfg_valid/o_cfg_ready with register index and data;
// ready is always high. Write only while the engine is idle.
// Throughput: a load is written into its store as it leaves the queue. An out-of-bounds
// compute strobes an error word with a zero result once it leaves the queue. A valid
// compute walks in_channels * kernel_rows * kernel_cols taps after it leaves the
// queue: one multiply-accumulate per cycle, set by the single read port of
// each store, then passes the read, multiply and accumulate stages.
// Reset: synchronous, clears the queue and the sequencer and restores the
// default sizes; the stores are not cleared and hold nothing until written.
`timescale 1ns / 1ps
`default_nettype none
module multichannel_conv2d_engine
    import mc2d_pkg::*;
#(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int MAX_IN_CH  = 8,
    parameter int MAX_OUT_CH = 16,
    parameter int MAX_KERNEL = 7
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            i_operation,
    input  wire logic [3:0]            i_out_channel,
    input  wire logic [2:0]            i_in_channel,
    input  wire logic [3:0]            i_row,
    input  wire logic [3:0]            i_col,
    input  wire logic signed [15:0]    i_value,
    output logic                       o_strobe,
    output logic signed [RES_W-1:0]    o_result,
    output logic                       o_error
);

    t_cfg    cfg;
    t_cmd    push_cmd;
    t_cmd    head;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    mc2d_front #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .MAX_IN_CH  (MAX_IN_CH),
        .MAX_OUT_CH (MAX_OUT_CH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_cfg_ready   (o_cfg_ready),
        .i_start       (start),
        .i_operation   (i_operation),
        .i_out_channel (i_out_channel),
        .i_in_channel  (i_in_channel),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_value       (i_value),
        .i_q_stat      (q_stat),
        .o_busy        (busy),
        .o_push        (push),
        .o_cmd         (push_cmd),
        .o_cfg         (cfg)
    );

    mc2d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    mc2d_back #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .MAX_IN_CH  (MAX_IN_CH),
        .MAX_OUT_CH (MAX_OUT_CH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_q_stat (q_stat),
        .i_head   (head),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .o_error  (o_error)
    );

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("result word right after reset");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_error) |-> (o_result == '0))
        else $error("error word with nonzero result");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");

endmodule
`default_nettype wire

// ===== verif/tb_multichannel_conv2d_engine.sv =====
// self-checking testbench for the multichannel valid-mode convolution engine
`timescale 1ns / 1ps
module tb_multichannel_conv2d_engine
    import mc2d_pkg::*;
();

    localparam int ROWS_MAX = 16;
    localparam int COLS_MAX = 16;
    localparam int ICH_MAX  = 8;
    localparam int OCH_MAX  = 16;
    localparam int KER_MAX  = 7;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 24;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         oc;
        logic [2:0]         ic;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [15:0] value;
    } t_cmd_word;

    typedef struct packed {
        logic signed [RES_W-1:0] sum;
        logic                    err;
    } t_sum_word;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              i_operation = '0;
    logic [3:0]              i_out_channel = '0;
    logic [2:0]              i_in_channel = '0;
    logic [3:0]              i_row = '0;
    logic [3:0]              i_col = '0;
    logic signed [15:0]      i_value = '0;
    logic                    o_strobe;
    logic signed [RES_W-1:0] o_result;
    logic                    o_error;

    multichannel_conv2d_engine u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_out_channel (i_out_channel),
        .i_in_channel  (i_in_channel),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_value       (i_value),
        .o_strobe      (o_strobe),
        .o_result      (o_result),
        .o_error       (o_error)
    );

    // sizes in use, clamped to the store bounds
    int n_rows  = RST_IN_ROWS;
    int n_cols  = RST_IN_COLS;
    int n_ich   = RST_IN_CH;
    int n_och   = RST_OUT_CH;
    int n_krows = RST_K_ROWS;
    int n_kcols = RST_K_COLS;
    int out_rows = RST_IN_ROWS - RST_K_ROWS + 1;
    int out_cols = RST_IN_COLS - RST_K_COLS + 1;

    logic signed [15:0] sample_mem [ICH_MAX][ROWS_MAX][COLS_MAX];
    bit                 sample_seen [ICH_MAX][ROWS_MAX][COLS_MAX];
    logic signed [15:0] coef_mem [OCH_MAX][ICH_MAX][KER_MAX][KER_MAX];
    bit                 coef_seen [OCH_MAX][ICH_MAX][KER_MAX][KER_MAX];

    t_sum_word pending_sums[$];
    int        error_count = 0;
    int        n_words = 0;
    int        n_sums = 0;
    int        idle_pct = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < 40) $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    function automatic int clamp_sz(input int v, input int lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic bit conv_hits_map(input t_cmd_word w);
        return w.oc < n_och && w.row < out_rows && w.col < out_cols;
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_cmd_word mk_word(input logic [1:0] op, input int oc, input int ic,
                                          input int row, input int col,
                                          input logic [15:0] value);
        t_cmd_word w;
        w.op    = op;
        w.oc    = 4'(oc);
        w.ic    = 3'(ic);
        w.row   = 4'(row);
        w.col   = 4'(col);
        w.value = value;
        return w;
    endfunction

    function automatic t_cmd_word rand_word();
        return mk_word(2'($urandom_range(3)), $urandom_range(15), $urandom_range(7),
                       $urandom_range(15), $urandom_range(15), 16'($urandom));
    endfunction

    // apply one accepted command to the mirrored stores, queue the sum it yields
    task automatic mirror_command(input t_cmd_word w);
        longint    acc;
        t_sum_word res;
        case (w.op)
            OP_LOAD_X: begin
                if (w.ic < n_ich && w.row < n_rows && w.col < n_cols) begin
                    sample_mem[w.ic][w.row][w.col]  = w.value;
                    sample_seen[w.ic][w.row][w.col] = 1'b1;
                end
            end
            OP_LOAD_W: begin
                if (w.oc < n_och && w.ic < n_ich && w.row < n_krows && w.col < n_kcols) begin
                    coef_mem[w.oc][w.ic][w.row][w.col]  = w.value;
                    coef_seen[w.oc][w.ic][w.row][w.col] = 1'b1;
                end
            end
            OP_CONV: begin
                res = '0;
                if (!conv_hits_map(w)) begin
                    res.err = 1'b1;
                end else begin
                    acc = 0;
                    for (int t = 0; t < n_ich; t++)
                        for (int i = 0; i < n_krows; i++)
                            for (int j = 0; j < n_kcols; j++)
                                acc += longint'(coef_mem[w.oc][t][i][j]) *
                                       longint'(sample_mem[t][w.row + i][w.col + j]);
                    res.sum = acc[RES_W-1:0];
                end
                pending_sums.push_back(res);
            end
            default: ;
        endcase
    endtask

    task automatic send_word(input t_cmd_word w);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start         <= 1'b1;
        i_operation   <= w.op;
        i_out_channel <= w.oc;
        i_in_channel  <= w.ic;
        i_row         <= w.row;
        i_col         <= w.col;
        i_value       <= w.value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        mirror_command(w);
        if (w.op != OP_UNUSED) n_words++;
    endtask

    // load every store entry the window reads that has not been written yet
    task automatic issue_conv(input t_cmd_word w);
        if (conv_hits_map(w)) begin
            for (int t = 0; t < n_ich; t++) begin
                for (int i = 0; i < n_krows; i++) begin
                    for (int j = 0; j < n_kcols; j++) begin
                        if (!coef_seen[w.oc][t][i][j])
                            send_word(mk_word(OP_LOAD_W, w.oc, t, i, j, pick_value()));
                        if (!sample_seen[t][w.row + i][w.col + j])
                            send_word(mk_word(OP_LOAD_X, $urandom_range(15), t,
                                              w.row + i, w.col + j, pick_value()));
                    end
                end
            end
        end
        send_word(w);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        // loads may still sit in the queue after the last sum
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [4:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_IN_ROWS: n_rows  = clamp_sz(data, ROWS_MAX);
            CFG_IN_COLS: n_cols  = clamp_sz(data, COLS_MAX);
            CFG_IN_CH:   n_ich   = clamp_sz(data[3:0], ICH_MAX);
            CFG_OUT_CH:  n_och   = clamp_sz(data, OCH_MAX);
            CFG_K_ROWS:  n_krows = clamp_sz(data[2:0], KER_MAX);
            CFG_K_COLS:  n_kcols = clamp_sz(data[2:0], KER_MAX);
            default: ;
        endcase
        out_rows = (n_krows == 0 || n_krows > n_rows) ? 0 : n_rows - n_krows + 1;
        out_cols = (n_kcols == 0 || n_kcols > n_cols) ? 0 : n_cols - n_kcols + 1;
    endtask

    task automatic set_sizes(input logic [4:0] rows, input logic [4:0] cols,
                             input logic [4:0] ich, input logic [4:0] och,
                             input logic [4:0] krows, input logic [4:0] kcols);
        write_reg(CFG_IN_ROWS, rows);
        write_reg(CFG_IN_COLS, cols);
        write_reg(CFG_IN_CH, ich);
        write_reg(CFG_OUT_CH, och);
        write_reg(CFG_K_ROWS, krows);
        write_reg(CFG_K_COLS, kcols);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [4:0] rows, input logic [4:0] cols,
                             input logic [4:0] ich, input logic [4:0] och,
                             input logic [4:0] krows, input logic [4:0] kcols,
                             input int budget);
        int        first;
        bit        paused;
        int        roll;
        t_cmd_word w;
        wait_quiet();
        set_sizes(rows, cols, ich, och, krows, kcols);
        first  = n_words;
        paused = 1'b0;
        while (n_words - first < budget) begin
            if (!paused && n_words - first >= budget / 2) begin
                // hold the command side until every sum is back
                wait_quiet();
                paused = 1'b1;
            end
            roll = $urandom_range(99);
            w = rand_word();
            if (roll < 6) begin
                // noise: every field random, the unused code included
            end else if (roll < 16) begin
                w.op = ($urandom_range(1) != 0) ? OP_LOAD_W : OP_LOAD_X;
            end else if (roll < 45) begin
                if ($urandom_range(1) != 0 && n_ich != 0 && n_rows != 0 && n_cols != 0) begin
                    w.op  = OP_LOAD_X;
                    w.ic  = 3'($urandom_range(n_ich - 1));
                    w.row = 4'($urandom_range(n_rows - 1));
                    w.col = 4'($urandom_range(n_cols - 1));
                end else if (n_och != 0 && n_ich != 0 && n_krows != 0 && n_kcols != 0) begin
                    w.op  = OP_LOAD_W;
                    w.oc  = 4'($urandom_range(n_och - 1));
                    w.ic  = 3'($urandom_range(n_ich - 1));
                    w.row = 4'($urandom_range(n_krows - 1));
                    w.col = 4'($urandom_range(n_kcols - 1));
                end else begin
                    w.op = OP_LOAD_X;
                end
                w.value = pick_value();
            end else begin
                w.op = OP_CONV;
                if (roll < 88 && n_och != 0 && out_rows != 0 && out_cols != 0) begin
                    w.oc  = 4'($urandom_range(n_och - 1));
                    w.row = 4'($urandom_range(out_rows - 1));
                    w.col = 4'($urandom_range(out_cols - 1));
                end
            end
            if (w.op == OP_CONV) issue_conv(w);
            else send_word(w);
        end
    endtask

    task automatic test_reset_sizes();
        idle_pct = 0;
        send_word(mk_word(OP_CONV, 0, 0, 8, 0, 16'h0000));
        send_word(mk_word(OP_CONV, 0, 0, 0, 8, 16'h0000));
        send_word(mk_word(OP_CONV, 15, 7, 8, 8, 16'hffff));
        send_word(mk_word(OP_LOAD_X, 0, 6, 0, 0, 16'h1234));
        send_word(mk_word(OP_UNUSED, 0, 0, 0, 0, 16'h0000));
    endtask

    // 2x2 map, one channel, 2x2 kernel: a single output position
    task automatic test_field_extremes();
        wait_quiet();
        set_sizes(5'd2, 5'd2, 5'd1, 5'd2, 5'd2, 5'd2);
        for (int k = 0; k < 4; k++)
            send_word(mk_word(OP_LOAD_X, 0, 0, k / 2, k % 2, 16'h8000));
        for (int k = 0; k < 4; k++)
            send_word(mk_word(OP_LOAD_W, 1, 0, k / 2, k % 2, 16'h8000));
        issue_conv(mk_word(OP_CONV, 1, 0, 0, 0, 16'h0000));
        send_word(mk_word(OP_LOAD_W, 1, 0, 1, 1, 16'h7fff));
        send_word(mk_word(OP_LOAD_X, 0, 0, 1, 1, 16'h7fff));
        issue_conv(mk_word(OP_CONV, 1, 0, 0, 0, 16'h0000));
        // loads beyond the sizes in use are dropped
        send_word(mk_word(OP_LOAD_X, 0, 7, 0, 0, 16'h1234));
        send_word(mk_word(OP_LOAD_X, 0, 0, 15, 15, 16'h1234));
        send_word(mk_word(OP_LOAD_W, 15, 0, 0, 0, 16'h1234));
        send_word(mk_word(OP_LOAD_W, 1, 0, 2, 0, 16'h1234));
        issue_conv(mk_word(OP_CONV, 15, 0, 15, 15, 16'h0000));
        issue_conv(mk_word(OP_CONV, 1, 0, 1, 0, 16'h0000));
        issue_conv(mk_word(OP_CONV, 2, 0, 0, 0, 16'h0000));
        send_word(mk_word(OP_UNUSED, 15, 7, 15, 15, 16'hffff));
        issue_conv(mk_word(OP_CONV, 1, 7, 0, 0, 16'hffff));
    endtask

    task automatic test_small_maps();
        idle_pct = 33;
        run_phase(5'd4, 5'd4, 5'd2, 5'd3, 5'd2, 5'd2, 60);
        run_phase(5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 40);
        run_phase(5'd16, 5'd16, 5'd1, 5'd16, 5'd1, 5'd1, 60);
        // kernel taller than the map: no output positions
        run_phase(5'd3, 5'd5, 5'd2, 5'd2, 5'd5, 5'd2, 30);
    endtask

    task automatic test_edge_sizes();
        idle_pct = 82;
        run_phase(5'd0, 5'd4, 5'd2, 5'd2, 5'd1, 5'd1, 25);
        // no input channels: in-bounds sums are zero
        run_phase(5'd5, 5'd5, 5'd0, 5'd4, 5'd3, 5'd3, 40);
        run_phase(5'd6, 5'd6, 5'd4, 5'd5, 5'd0, 5'd3, 25);
        run_phase(5'd12, 5'd12, 5'd6, 5'd16, 5'd5, 5'd5, 150);
    endtask

    task automatic test_large_maps();
        idle_pct = 0;
        // every size register at or above its bound, upper data bits set on the narrow ones
        run_phase(5'd31, 5'd31, 5'd31, 5'd31, 5'd15, 5'd15, 300);
        run_phase(5'd8, 5'd9, 5'd1, 5'd4, 5'd7, 5'd3, 60);
        run_phase(5'd16, 5'd7, 5'd2, 5'd2, 5'd4, 5'd4, 60);
    endtask

    always @(posedge i_clk) begin : check_sums
        t_sum_word want;
        if (i_rst_n && o_strobe) begin
            if (pending_sums.size() == 0) begin
                report_mismatch($sformatf("sum word %0d err %0b with none pending",
                                          o_result, o_error));
            end else begin
                want = pending_sums.pop_front();
                if (o_error !== want.err)
                    report_mismatch($sformatf("word %0d: error %0b, want %0b",
                                              n_sums, o_error, want.err));
                if (o_result !== want.sum)
                    report_mismatch($sformatf("word %0d: result %0d, want %0d",
                                              n_sums, o_result, want.sum));
            end
            n_sums++;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_sizes();
        test_field_extremes();
        test_small_maps();
        test_edge_sizes();
        test_large_maps();
        wait_quiet();
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
